FILE: src/plrs_pkg.sv
// Shared constants, command and status types for the polyline resampler.
// No dependencies; imported by every module of the block.
package plrs_pkg;

  localparam int COORD_BITS    = 10;
  localparam int FIELD_BITS    = 10;
  localparam int MAX_SAMPLES   = 64;
  localparam int SPACING_BITS  = 8;
  localparam int FRAC_BITS     = 6;
  localparam int OUT_BITS      = 16;
  localparam int IN_DATA_BITS  = 24;
  localparam int OUT_DATA_BITS = 32;

  // count must also hold the clamp probe MAX_SAMPLES+1
  localparam int CNT_BITS      = $clog2(MAX_SAMPLES + 2);
  localparam int STEP_BITS     = $clog2(CNT_BITS + 1);
  localparam int DIV_BITS      = COORD_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIV_BITS + 1);
  localparam int LEN_BITS      = CNT_BITS + SPACING_BITS;
  localparam int SQ_BITS       = 2 * LEN_BITS;
  localparam int DIST_BITS     = 2 * COORD_BITS + 1;

  localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(5);
  localparam logic [CNT_BITS-1:0]     CLAMP_PROBE   = CNT_BITS'(MAX_SAMPLES + 1);
  localparam logic [CNT_BITS-1:0]     MAX_COUNT     = CNT_BITS'(MAX_SAMPLES);

  localparam logic KIND_POINT = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic load;        // capture input item
    logic sq_x;        // dist2 = dx^2
    logic sq_y;        // dist2 += dy^2
    logic srch_init;   // clear count search
    logic srch_mul;    // len = cand * spacing
    logic srch_cmp;    // len^2 <= dist2 ?
    logic div_start;   // load divider
    logic div_sel_y;   // divider operand select
    logic div_step;    // one quotient bit
    logic latch_x;     // keep x quotient/remainder
    logic latch_y;     // keep y quotient/remainder, reset accumulators
    logic emit;        // write interpolated sample to output register
    logic emit_end;    // write stored point to output register
  } cmd_t;

  typedef struct packed {
    logic have_prev;
    logic srch_last;
    logic n_zero;
    logic div_done;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

FILE: src/plrs_div.sv
// Restoring divider, one quotient bit per cycle while step is asserted.
// Depends on plrs_pkg; used by plrs_datapath.
module plrs_div
  import plrs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                step,
  input  logic [DIV_BITS-1:0] dividend,
  input  logic [CNT_BITS-1:0] divisor,
  output logic [DIV_BITS-1:0] quotient,
  output logic [CNT_BITS-1:0] remainder,
  output logic                done
);

  logic [DIV_BITS-1:0]     dq;
  logic [CNT_BITS-1:0]     rem;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [CNT_BITS:0]       trial;
  logic                    fits;

  assign trial = {rem, dq[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_BITS'(DIV_BITS);
    end else if (step && cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= dividend;
      rem <= '0;
    end else if (step && cnt != '0) begin
      dq  <= {dq[DIV_BITS-2:0], fits};
      rem <= fits ? CNT_BITS'(trial - {1'b0, divisor}) : trial[CNT_BITS-1:0];
    end
  end

  assign quotient  = dq;
  assign remainder = rem;
  assign done      = (cnt == '0);

endmodule

FILE: src/plrs_datapath.sv
// Datapath: stored point, distance, count search, divider and sample accumulators.
// Depends on plrs_pkg and plrs_div; driven by plrs_ctrl commands.
module plrs_datapath
  import plrs_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [SPACING_BITS-1:0] cfg_wr_data,
  input  logic                    kind,
  input  logic [FIELD_BITS-1:0]   point_x,
  input  logic [FIELD_BITS-1:0]   point_y,
  input  cmd_t                    cmd,
  output stat_t                   stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [OUT_BITS-1:0]     out_x,
  output logic [OUT_BITS-1:0]     out_y,
  output logic                    out_last,
  output logic                    out_clamped
);

  logic [SPACING_BITS-1:0] spacing;
  logic [COORD_BITS-1:0]   prev_x, prev_y;
  logic                    have_prev;
  logic [COORD_BITS-1:0]   base_x, base_y;
  logic [COORD_BITS-1:0]   mag_x, mag_y;
  logic                    sgn_x, sgn_y;
  logic [DIST_BITS-1:0]    dist2;

  logic [COORD_BITS-1:0]   px, py;
  logic [COORD_BITS:0]     dx, dy;
  logic [COORD_BITS-1:0]   sq_op;
  logic [2*COORD_BITS-1:0] sq;

  // count search
  logic [STEP_BITS-1:0]    step;
  logic [CNT_BITS-1:0]     n;
  logic                    clamped;
  logic [CNT_BITS-1:0]     cand;
  logic [LEN_BITS-1:0]     len;
  logic [SQ_BITS-1:0]      len_sq;
  logic                    pass;

  // divider
  logic [DIV_BITS-1:0]     div_q;
  logic [CNT_BITS-1:0]     div_r;
  logic                    div_done;
  logic [DIV_BITS-1:0]     dividend;

  // sample accumulators
  logic [DIV_BITS-1:0]     quo_x, quo_y, acc_x, acc_y;
  logic [CNT_BITS-1:0]     rmd_x, rmd_y, racc_x, racc_y;
  logic [CNT_BITS-1:0]     j;
  logic [CNT_BITS:0]       rsum_x, rsum_y;
  logic                    wrap_x, wrap_y;
  logic [DIV_BITS-1:0]     off_x, off_y;
  logic [DIV_BITS-1:0]     samp_x, samp_y;

  assign px = COORD_BITS'(point_x);
  assign py = COORD_BITS'(point_y);
  assign dx = {1'b0, px} - {1'b0, prev_x};
  assign dy = {1'b0, py} - {1'b0, prev_y};

  always_ff @(posedge clk) begin
    if (rst) begin
      spacing <= SPACING_RESET;
    end else if (cfg_wr_en) begin
      spacing <= cfg_wr_data;
    end
  end

  // stored key point
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_x    <= '0;
      prev_y    <= '0;
      have_prev <= 1'b0;
    end else if (cmd.load) begin
      if (kind == KIND_END) begin
        prev_x    <= '0;
        prev_y    <= '0;
        have_prev <= 1'b0;
      end else begin
        prev_x    <= px;
        prev_y    <= py;
        have_prev <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_x <= prev_x;
      base_y <= prev_y;
      sgn_x  <= dx[COORD_BITS];
      sgn_y  <= dy[COORD_BITS];
      mag_x  <= dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
      mag_y  <= dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    end
  end

  // squared distance: dx^2, then dy^2 added, sharing one multiplier
  assign sq_op = cmd.sq_y ? mag_y : mag_x;
  assign sq    = sq_op * sq_op;

  always_ff @(posedge clk) begin
    if (cmd.sq_x) begin
      dist2 <= DIST_BITS'(sq);
    end else if (cmd.sq_y) begin
      dist2 <= dist2 + DIST_BITS'(sq);
    end
  end

  // count search: clamp probe first, then one count bit per step, MSB first
  assign cand   = (step == '0) ? CLAMP_PROBE
                               : (n | (CNT_BITS'(1) << (CNT_BITS - int'(step))));
  assign len_sq = len * len;
  assign pass   = len_sq <= SQ_BITS'(dist2);

  always_ff @(posedge clk) begin
    if (cmd.srch_mul) begin
      len <= LEN_BITS'(cand) * LEN_BITS'(spacing);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.srch_init) begin
      step    <= '0;
      n       <= '0;
      clamped <= 1'b0;
    end else if (cmd.srch_cmp) begin
      step <= step + 1'b1;
      if (step == '0) begin
        clamped <= pass;
      end else if (pass && cand <= MAX_COUNT) begin
        n <= cand;
      end
    end
  end

  assign dividend = cmd.div_sel_y ? {mag_y, FRAC_BITS'(0)} : {mag_x, FRAC_BITS'(0)};

  plrs_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .step      (cmd.div_step),
    .dividend  (dividend),
    .divisor   (n),
    .quotient  (div_q),
    .remainder (div_r),
    .done      (div_done)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_x) begin
      quo_x <= div_q;
      rmd_x <= div_r;
    end
    if (cmd.latch_y) begin
      quo_y <= div_q;
      rmd_y <= div_r;
    end
  end

  // running j*|d|*64/n as quotient plus remainder
  assign rsum_x = {1'b0, racc_x} + {1'b0, rmd_x};
  assign rsum_y = {1'b0, racc_y} + {1'b0, rmd_y};
  assign wrap_x = rsum_x >= {1'b0, n};
  assign wrap_y = rsum_y >= {1'b0, n};

  always_ff @(posedge clk) begin
    if (cmd.latch_y) begin
      j      <= '0;
      acc_x  <= '0;
      acc_y  <= '0;
      racc_x <= '0;
      racc_y <= '0;
    end else if (cmd.emit) begin
      j      <= j + 1'b1;
      acc_x  <= acc_x + quo_x + DIV_BITS'(wrap_x);
      acc_y  <= acc_y + quo_y + DIV_BITS'(wrap_y);
      racc_x <= wrap_x ? CNT_BITS'(rsum_x - {1'b0, n}) : rsum_x[CNT_BITS-1:0];
      racc_y <= wrap_y ? CNT_BITS'(rsum_y - {1'b0, n}) : rsum_y[CNT_BITS-1:0];
    end
  end

  // truncation toward zero: negate the magnitude quotient
  assign off_x  = sgn_x ? (DIV_BITS'(0) - acc_x) : acc_x;
  assign off_y  = sgn_y ? (DIV_BITS'(0) - acc_y) : acc_y;
  assign samp_x = {base_x, FRAC_BITS'(0)} + off_x;
  assign samp_y = {base_y, FRAC_BITS'(0)} + off_y;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x       <= OUT_BITS'(samp_x);
      out_y       <= OUT_BITS'(samp_y);
      out_last    <= (j == n - 1'b1);
      out_clamped <= clamped;
    end else if (cmd.emit_end) begin
      out_x       <= OUT_BITS'({base_x, FRAC_BITS'(0)});
      out_y       <= OUT_BITS'({base_y, FRAC_BITS'(0)});
      out_last    <= 1'b1;
      out_clamped <= 1'b0;
    end
  end

  assign stat.have_prev = have_prev;
  assign stat.srch_last = (step == STEP_BITS'(CNT_BITS));
  assign stat.n_zero    = (n == '0);
  assign stat.div_done  = div_done;
  assign stat.emit_last = (j == n - 1'b1);
  assign stat.out_free  = !out_valid || out_ready;

endmodule

FILE: src/plrs_ctrl.sv
// Sequencer for the resampler: steps the datapath through each item.
// Depends on plrs_pkg; talks to plrs_datapath by cmd_t / stat_t only.
module plrs_ctrl
  import plrs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_kind,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_SQ_X    = 9'b000000010,
    ST_SQ_Y    = 9'b000000100,
    ST_S_MUL   = 9'b000001000,
    ST_S_CMP   = 9'b000010000,
    ST_DIV_X   = 9'b000100000,
    ST_DIV_Y   = 9'b001000000,
    ST_EMIT    = 9'b010000000,
    ST_END_OUT = 9'b100000000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.have_prev) begin
            state_next = (in_kind == KIND_END) ? ST_END_OUT : ST_SQ_X;
          end
        end
      end
      ST_SQ_X: begin
        cmd.sq_x   = 1'b1;
        state_next = ST_SQ_Y;
      end
      ST_SQ_Y: begin
        cmd.sq_y      = 1'b1;
        cmd.srch_init = 1'b1;
        state_next    = ST_S_MUL;
      end
      ST_S_MUL: begin
        cmd.srch_mul = 1'b1;
        state_next   = ST_S_CMP;
      end
      ST_S_CMP: begin
        cmd.srch_cmp = 1'b1;
        if (stat.srch_last) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV_X;
        end else begin
          state_next = ST_S_MUL;
        end
      end
      ST_DIV_X: begin
        if (stat.n_zero) begin
          state_next = ST_IDLE;
        end else if (stat.div_done) begin
          cmd.latch_x   = 1'b1;
          cmd.div_start = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_next    = ST_DIV_Y;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DIV_Y: begin
        if (stat.div_done) begin
          cmd.latch_y = 1'b1;
          state_next  = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.emit_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_END_OUT: begin
        if (stat.out_free) begin
          cmd.emit_end = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/polyline_uniform_resampler_core.sv
// Top level of the polyline uniform resampler: sequencer plus datapath.
// Depends on plrs_pkg, plrs_ctrl, plrs_datapath (and plrs_div below it).
//
// Channel   Dir  Signals                         Payload (low bit up)
// s_axis    in   tvalid/tready/tdata/tuser       tdata: point_x, point_y; tuser: kind
// m_axis    out  tvalid/tready/tdata/tlast/tuser tdata: sample_x, sample_y;
//                                                tlast: last_of_run; tuser: count_clamped
// cfg       in   cfg_wr_en/cfg_wr_data           sample_spacing, no read-back
//
// A first key point or a bare end item is only taken in; an end with a stored point
// also emits that point. Segment item: accept, squares of dx and dy, count search (8 probes,
// multiply then compare each, one squarer), the shared bit-serial divider (x then y), then
// n samples, one per cycle while the output is free. n = 0 ends after the search.
// One item at a time; the output register lets the last sample wait while
// the next item is taken. m_axis stalls simply freeze sample generation.
// Reset (rst, sync): no stored point, spacing 5, output empty.
module polyline_uniform_resampler_core
  import plrs_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  // configuration
  input  logic                     cfg_wr_en,
  input  logic [SPACING_BITS-1:0]  cfg_wr_data,     // sample_spacing
  // key point input
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,    // point_x[9:0], point_y[19:10], pad
  input  logic                     s_axis_tuser,    // kind
  // sample output
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,    // sample_x[15:0], sample_y[31:16]
  output logic                     m_axis_tlast,    // last_of_run
  output logic                     m_axis_tuser     // count_clamped
);

  cmd_t  cmd;
  stat_t stat;

  logic                in_valid;
  logic [OUT_BITS-1:0] out_x, out_y;

  // only the handshake qualifies the sequencer's view of the input
  assign in_valid = s_axis_tvalid;

  plrs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_kind  (s_axis_tuser),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  plrs_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .kind        (s_axis_tuser),
    .point_x     (s_axis_tdata[FIELD_BITS-1:0]),
    .point_y     (s_axis_tdata[2*FIELD_BITS-1:FIELD_BITS]),
    .cmd         (cmd),
    .stat        (stat),
    .out_ready   (m_axis_tready),
    .out_valid   (m_axis_tvalid),
    .out_x       (out_x),
    .out_y       (out_y),
    .out_last    (m_axis_tlast),
    .out_clamped (m_axis_tuser)
  );

  assign m_axis_tdata = {out_y, out_x};

`ifndef SYNTHESIS
  // sequencer never overwrites a sample that is still waiting
  a_emit_into_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit || cmd.emit_end) |-> stat.out_free)
    else $error("sample written while output register busy");

  // the last sample of a segment returns the block to accepting items
  a_last_then_ready: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && stat.emit_last) |=> s_axis_tready)
    else $error("not ready after final sample of a segment");

  // the y division only completes for a nonzero segment count
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.latch_y |-> !stat.n_zero)
    else $error("division finished with zero count");
`endif

endmodule

FILE: tb/tb.sv
// Self-checking bench for polyline_uniform_resampler_core: key points in, resampled points out.
// Needs plrs_pkg and the core RTL. Expected samples come from an in-bench predictor of
// the segment count search and the truncating interpolation.
module tb;
  import plrs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  kind;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] x;
  } item_t;

  typedef struct packed {
    logic [OUT_BITS-1:0] x;
    logic [OUT_BITS-1:0] y;
    logic                last;
    logic                clamped;
  } sample_t;

  // receiver behaviors: always ready, coin flip per cycle, occasional stall runs
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_BURSTY} rx_mode_t;

  localparam int COORD_MAX = (1 << COORD_BITS) - 1;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_wr_en = 1'b0;
  logic [SPACING_BITS-1:0]  cfg_wr_data = '0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;   // point_x, point_y, zero pad
  logic                     s_axis_tuser = 1'b0; // kind
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;        // sample_x, sample_y
  logic                     m_axis_tlast;        // last_of_run
  logic                     m_axis_tuser;        // count_clamped

  polyline_uniform_resampler_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the spacing register and the stored point.
  // ---------------------------------------------------------------------------
  logic [SPACING_BITS-1:0] spacing_now = SPACING_RESET;
  logic [COORD_BITS-1:0]   trail_x = '0;
  logic [COORD_BITS-1:0]   trail_y = '0;
  logic                    has_point = 1'b0;

  item_t   pending_items[$];  // items waiting for the driver
  sample_t samples_due[$];    // predicted samples, oldest first

  int items_queued = 0;
  int items_accepted = 0;
  int samples_checked = 0;
  int errors = 0;
  int phases_run = 0;

  // Largest n <= MAX_SAMPLES with (n*s)^2 <= dist2; clamped if MAX_SAMPLES+1 also fits.
  function automatic void count_segments(input longint unsigned dist2,
                                         input longint unsigned s,
                                         output int unsigned n, output bit clamped);
    longint unsigned len;
    n = 0;
    for (int k = 1; k <= MAX_SAMPLES; k++) begin
      len = longint'(k) * s;
      if (len * len <= dist2) n = k;
    end
    len = longint'(MAX_SAMPLES + 1) * s;
    clamped = (len * len <= dist2);
  endfunction

  // p*64 + j*d*64/n, quotient truncated toward zero (signed divide does that)
  function automatic logic [OUT_BITS-1:0] interp_coord(input logic [COORD_BITS-1:0] p,
                                                        input longint d,
                                                        input int j, input int n);
    longint num;
    longint q;
    num = longint'(j) * d * (1 << FRAC_BITS);
    q = num / longint'(n);
    return OUT_BITS'(longint'(p) * (1 << FRAC_BITS) + q);
  endfunction

  // Apply one accepted item to the predictor and queue the samples it causes.
  task automatic advance_polyline(input item_t it);
    longint          dx;
    longint          dy;
    longint unsigned dist2;
    int unsigned     n;
    bit              clamped;
    sample_t         s;
    if (it.kind == KIND_END) begin
      // end of polyline: flush the stored point exactly, then forget it
      if (has_point) begin
        s.x = {trail_x, {FRAC_BITS{1'b0}}};
        s.y = {trail_y, {FRAC_BITS{1'b0}}};
        s.last = 1'b1;
        s.clamped = 1'b0;
        samples_due.insert(samples_due.size(), s);
        has_point = 1'b0;
        trail_x = '0;
        trail_y = '0;
      end
    end else if (!has_point) begin
      // first key point only gets stored
      trail_x = it.x;
      trail_y = it.y;
      has_point = 1'b1;
    end else begin
      dx = longint'(it.x) - longint'(trail_x);
      dy = longint'(it.y) - longint'(trail_y);
      dist2 = longint'(dx * dx + dy * dy);
      count_segments(dist2, longint'(spacing_now), n, clamped);
      for (int j = 0; j < n; j++) begin
        s.x = interp_coord(trail_x, dx, j, n);
        s.y = interp_coord(trail_y, dy, j, n);
        s.last = (j + 1 == n);
        s.clamped = clamped;
        samples_due.insert(samples_due.size(), s);
      end
      trail_x = it.x;
      trail_y = it.y;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of random length separated by random gaps. Prediction runs at
  // the edge where the item is accepted, so it always sees the current spacing.
  // ---------------------------------------------------------------------------
  item_t tx_item = '0;
  bit    tx_offer;
  bit    tx_steady = 1'b0;  // phase without sender gaps
  int    gap_left = 0;
  int    burst_left = 0;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      tx_offer = s_axis_tvalid;
      if (s_axis_tvalid && s_axis_tready) begin
        advance_polyline(tx_item);
        items_accepted++;
        tx_offer = 1'b0;
      end
      if (!tx_offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          tx_item = pending_items.pop_front();
          tx_offer = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 10);
            if (tx_steady || $urandom_range(0, 2) == 0) gap_left = 0;
            else gap_left = $urandom_range(1, 12);
          end
        end
      end
      s_axis_tvalid <= tx_offer;
      s_axis_tdata  <= IN_DATA_BITS'({tx_item.y, tx_item.x});
      s_axis_tuser  <= tx_item.kind;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern picked per phase, plus one long hold-off below.
  // ---------------------------------------------------------------------------
  rx_mode_t rx_mode = RX_OPEN;
  logic     hold_off = 1'b0;
  int       rx_run = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_run = 0;
    end else if (hold_off) begin
      m_axis_tready <= 1'b0;
    end else if (rx_run > 0) begin
      rx_run--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          m_axis_tready <= 1'b1;
        end
        RX_COIN: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if ($urandom_range(0, 7) == 0) begin
            rx_run = $urandom_range(1, 8);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Long output stall in a dense phase: sender keeps offering, core must back up.
  initial begin
    do @(posedge clk); while (items_accepted < 30);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted sample is checked against the oldest prediction.
  // ---------------------------------------------------------------------------
  sample_t mon_got;
  sample_t mon_want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      mon_got.x = m_axis_tdata[OUT_BITS-1:0];
      mon_got.y = m_axis_tdata[2*OUT_BITS-1:OUT_BITS];
      mon_got.last = m_axis_tlast;
      mon_got.clamped = m_axis_tuser;
      samples_checked++;
      if (samples_due.size() == 0) begin
        $display("%0t: sample with none expected: x=%h y=%h last=%b clamped=%b",
                 $time, mon_got.x, mon_got.y, mon_got.last, mon_got.clamped);
        errors++;
      end else begin
        mon_want = samples_due.pop_front();
        if (mon_got.x !== mon_want.x) begin
          $display("%0t: sample_x expected %h got %h", $time, mon_want.x, mon_got.x);
          errors++;
        end
        if (mon_got.y !== mon_want.y) begin
          $display("%0t: sample_y expected %h got %h", $time, mon_want.y, mon_got.y);
          errors++;
        end
        if (mon_got.last !== mon_want.last) begin
          $display("%0t: last_of_run expected %b got %b", $time, mon_want.last, mon_got.last);
          errors++;
        end
        if (mon_got.clamped !== mon_want.clamped) begin
          $display("%0t: count_clamped expected %b got %b", $time,
                   mon_want.clamped, mon_got.clamped);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  int gen_x = 0;  // last key point handed to the queue, for nearby steps
  int gen_y = 0;

  task automatic push_item(input logic kind, input int x, input int y);
    item_t it;
    it.kind = kind;
    it.x = COORD_BITS'(x);
    it.y = COORD_BITS'(y);
    pending_items.insert(pending_items.size(), it);
    items_queued++;
    if (kind == KIND_POINT) begin
      gen_x = x;
      gen_y = y;
    end
  endtask

  function automatic int clip_coord(input int v);
    return (v < 0) ? 0 : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  // Mostly key points (long, short and degenerate segments), now and then an end.
  task automatic queue_random_items(input int count);
    int nx;
    int ny;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 11) == 0) begin
        push_item(KIND_END, $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX));
      end else begin
        case ($urandom_range(0, 4))
          0, 1: begin
            nx = $urandom_range(0, COORD_MAX);
            ny = $urandom_range(0, COORD_MAX);
          end
          2: begin
            nx = clip_coord(gen_x + $urandom_range(0, 40) - 20);
            ny = clip_coord(gen_y + $urandom_range(0, 40) - 20);
          end
          3: begin
            nx = clip_coord(gen_x + $urandom_range(0, 400) - 200);
            ny = clip_coord(gen_y + $urandom_range(0, 400) - 200);
          end
          default: begin
            nx = $urandom_range(0, 1) ? COORD_MAX : 0;
            ny = $urandom_range(0, 1) ? COORD_MAX : 0;
          end
        endcase
        push_item(KIND_POINT, nx, ny);
      end
    end
  endtask

  // Wait until all items are in and all samples are out, then let a pending
  // no-result item (short segment) finish before the register is touched.
  task automatic settle();
    do @(posedge clk); while (items_accepted != items_queued || samples_due.size() != 0);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_spacing(input logic [SPACING_BITS-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    spacing_now = v;
  endtask

  logic [SPACING_BITS-1:0] phase_spacing[8];

  initial begin
    phase_spacing = '{8'd1, 8'd255, 8'd0, 8'd5, 8'd2, 8'd13, 8'd40, 8'd128};
    phase_spacing[4] = SPACING_BITS'($urandom_range(1, 20));
    phase_spacing[5] = SPACING_BITS'($urandom_range(1, 60));
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed run at the reset spacing of 5.
    rx_mode <= RX_BURSTY;
    push_item(KIND_END, COORD_MAX, COORD_MAX);    // end with nothing stored
    push_item(KIND_POINT, 0, 0);                  // first point, stored only
    push_item(KIND_POINT, COORD_MAX, COORD_MAX);  // full diagonal, clamped
    push_item(KIND_POINT, COORD_MAX, COORD_MAX);  // zero-length segment
    push_item(KIND_POINT, 1020, 1021);            // shorter than one spacing
    push_item(KIND_POINT, 1015, 1021);            // exactly one spacing, dx < 0
    push_item(KIND_POINT, 0, 1021);               // long run leftward
    push_item(KIND_POINT, 0, 0);                  // long run upward
    push_item(KIND_POINT, 3, 4);                  // 3-4-5 length, n = 1 boundary
    push_item(KIND_POINT, 0, 0);
    push_item(KIND_POINT, 7, 24);                 // length 25, five samples
    push_item(KIND_END, 0, 0);                    // flush stored point
    push_item(KIND_END, 512, 512);                // second end, nothing left
    push_item(KIND_POINT, COORD_MAX, 0);
    push_item(KIND_POINT, COORD_MAX, COORD_MAX);  // vertical, clamped
    push_item(KIND_POINT, 700, 500);              // both deltas negative
    push_item(KIND_POINT, 701, 530);              // uneven fractions
    push_item(KIND_END, 0, COORD_MAX);
    settle();
    phases_run++;

    // Random runs, one spacing each, extremes included.
    foreach (phase_spacing[p]) begin
      write_spacing(phase_spacing[p]);
      rx_mode   <= rx_mode_t'($urandom_range(0, 2));
      tx_steady <= ($urandom_range(0, 3) == 0);
      if (phase_spacing[p] == 0) begin
        // repeated point: zero length still yields a full clamped run
        push_item(KIND_POINT, 512, 300);
        push_item(KIND_POINT, 512, 300);
      end
      queue_random_items(18);
      settle();
      phases_run++;
    end

    $display("Covered %0d input items and %0d samples over %0d spacing settings,",
             items_accepted, samples_checked, phases_run);
    $display("including zero, minimum and maximum spacing and a long output stall.");
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timeout: %0d items pending, %0d samples outstanding",
             items_queued - items_accepted, samples_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: polyline_uniform_resampler_core.f
src/plrs_pkg.sv
src/plrs_div.sv
src/plrs_datapath.sv
src/plrs_ctrl.sv
src/polyline_uniform_resampler_core.sv
tb/tb.sv
